// ===== rtl/gbdi_pkg.sv =====
// package for the gyro bias / deadband integrator
// request and response payload types, codes, fixed-point constants and
// the constant-divider helpers; depends on nothing
`timescale 1ns / 1ps

package gbdi_pkg;

  // calibration length and derived widths
  localparam int CALIB_SAMPLES = 100;
  localparam int CNT_W         = $clog2(CALIB_SAMPLES + 1);

  localparam int RATE_W  = 16;
  localparam int DT_W    = 16;
  localparam int ACC_W   = 16;
  localparam int ANGLE_W = 48;
  localparam int SUM_W   = 23;
  localparam int THR_W   = 32;
  localparam int SQ_W    = 31;
  localparam int DELTA_W = 33;

  localparam logic [THR_W-1:0] THR_RESET = 32'd131537961;

  localparam logic signed [RATE_W-1:0] RATE_MAX_RESET = 16'sd0;
  localparam logic signed [RATE_W-1:0] RATE_MIN_RESET = 16'sd32;
  localparam logic signed [RATE_W-1:0] RATE_POS_LIMIT = 16'sd32767;

  // request codes
  localparam logic [1:0] REQ_CALIB = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_ACCEL = 2'd2;

  // divide by ten: exact for dividends below 2**DIV10_N
  localparam int DIV10_N     = 19;
  localparam int DIV10_SHIFT = DIV10_N + 4;
  localparam int DIV10_RW    = DIV10_N + 1;
  localparam logic [DIV10_RW-1:0] DIV10_RECIP =
    DIV10_RW'(((64'd1 << DIV10_SHIFT) + 64'd9) / 64'd10);

  // divide by the sample count: exact for dividends below 2**SUM_MAG_W
  localparam int SUM_MAG_W   = SUM_W - 1;
  localparam int BIAS_SHIFT  = SUM_MAG_W + $clog2(CALIB_SAMPLES);
  localparam int BIAS_RW     = SUM_MAG_W + 1;
  localparam logic [BIAS_RW-1:0] BIAS_RECIP =
    BIAS_RW'(((64'd1 << BIAS_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [RATE_W-1:0] gyro_rate;
    logic [DT_W-1:0]          dt_us;
    logic signed [ACC_W-1:0]  accel_x;
    logic signed [ACC_W-1:0]  accel_y;
    logic signed [ACC_W-1:0]  accel_z;
  } gbdi_req_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      collision;
    logic                      calibrated;
  } gbdi_rsp_t;

  // gyro lane result handed to the merge stage
  typedef struct packed {
    logic                      acc_en;
    logic signed [DELTA_W-1:0] delta;
    logic                      calibrated;
  } gbdi_gyro_t;

  function automatic logic [DIV10_N-1:0] div10(input logic [DIV10_N-1:0] n);
    logic [DIV10_N+DIV10_RW-1:0] p;
    p = (DIV10_N+DIV10_RW)'(n) * (DIV10_N+DIV10_RW)'(DIV10_RECIP);
    return DIV10_N'(p >> DIV10_SHIFT);
  endfunction

  function automatic logic [SUM_MAG_W-1:0] div_calib(input logic [SUM_MAG_W-1:0] n);
    logic [SUM_MAG_W+BIAS_RW-1:0] p;
    p = (SUM_MAG_W+BIAS_RW)'(n) * (SUM_MAG_W+BIAS_RW)'(BIAS_RECIP);
    return SUM_MAG_W'(p >> BIAS_SHIFT);
  endfunction

endpackage

// ===== rtl/gbdi_sq_lane.sv =====
// one accelerometer lane: registered square of a signed axis sample
// uses gbdi_pkg for widths
`timescale 1ns / 1ps

module gbdi_sq_lane (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [gbdi_pkg::ACC_W-1:0] axis,
  output logic [gbdi_pkg::SQ_W-1:0]        sq
);

  logic signed [2*gbdi_pkg::ACC_W-1:0] prod;

  assign prod = axis * axis;

  always_ff @(posedge clk) begin
    if (en) begin
      sq <= gbdi_pkg::SQ_W'(prod);
    end
  end

endmodule

// ===== rtl/gbdi_gyro_core.sv =====
// gyro lane: calibration tracking, bias and deadband bounds, and the
// registered (rate - bias) * dt product; uses gbdi_pkg
`timescale 1ns / 1ps

module gbdi_gyro_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  gbdi_pkg::gbdi_req_t   req,
  output gbdi_pkg::gbdi_gyro_t  gyro
);

  localparam int RW = gbdi_pkg::RATE_W;
  localparam int N  = gbdi_pkg::DIV10_N;
  localparam int MW = gbdi_pkg::SUM_MAG_W;

  // after calibration rate_max / rate_min hold the upper / lower bounds
  logic signed [RW-1:0]              rate_max, rate_max_next;
  logic signed [RW-1:0]              rate_min, rate_min_next;
  logic signed [gbdi_pkg::SUM_W-1:0] rate_sum, rate_sum_next;
  logic [gbdi_pkg::CNT_W-1:0]        sample_count, sample_count_next;
  logic signed [RW-1:0]              bias, bias_next;
  logic                              cal_done, cal_done_next;

  logic signed [RW-1:0]              rate;
  logic signed [RW-1:0]              max_upd, min_upd;
  logic signed [gbdi_pkg::SUM_W-1:0] sum_upd;
  logic [gbdi_pkg::CNT_W-1:0]        cnt_upd;
  logic                              is_cal, last_sample;
  logic [N-1:0]                      max11, hi_q, min_mag, lo_q;
  logic signed [RW-1:0]              hi_bound, lo_bound;
  logic [MW-1:0]                     sum_mag, bias_q;
  logic                              outside;
  logic signed [RW:0]                diff;
  logic signed [2*RW+1:0]            prod;

  assign rate   = req.gyro_rate;
  assign is_cal = (req.req_type == gbdi_pkg::REQ_CALIB) && !cal_done;

  assign max_upd     = (rate > rate_max) ? rate : rate_max;
  assign min_upd     = (rate < rate_min) ? rate : rate_min;
  assign sum_upd     = rate_sum + gbdi_pkg::SUM_W'(rate);
  assign cnt_upd     = sample_count + 1'b1;
  assign last_sample = cnt_upd >= gbdi_pkg::CNT_W'(gbdi_pkg::CALIB_SAMPLES);

  // max never goes below its zero start, so the upper bound is unsigned work
  assign max11    = N'(max_upd[RW-2:0]) * N'(11);
  assign hi_q     = gbdi_pkg::div10(max11);
  assign hi_bound = (hi_q > N'(gbdi_pkg::RATE_POS_LIMIT)) ? gbdi_pkg::RATE_POS_LIMIT
                                                          : RW'(hi_q);

  // lower bound and bias truncate toward zero: divide the magnitude
  assign min_mag  = min_upd[RW-1] ? N'(-32'(min_upd)) : N'(min_upd);
  assign lo_q     = gbdi_pkg::div10(min_mag);
  assign lo_bound = min_upd[RW-1] ? -RW'(lo_q) : RW'(lo_q);

  assign sum_mag  = sum_upd[gbdi_pkg::SUM_W-1] ? MW'(-sum_upd) : MW'(sum_upd);
  assign bias_q   = gbdi_pkg::div_calib(sum_mag);

  always_comb begin
    rate_max_next     = rate_max;
    rate_min_next     = rate_min;
    rate_sum_next     = rate_sum;
    sample_count_next = sample_count;
    bias_next         = bias;
    cal_done_next     = cal_done;
    if (is_cal) begin
      rate_sum_next     = sum_upd;
      sample_count_next = cnt_upd;
      if (last_sample) begin
        rate_max_next = hi_bound;
        rate_min_next = lo_bound;
        bias_next     = sum_upd[gbdi_pkg::SUM_W-1] ? -RW'(bias_q) : RW'(bias_q);
        cal_done_next = 1'b1;
      end else begin
        rate_max_next = max_upd;
        rate_min_next = min_upd;
      end
    end
  end

  // run path: deadband test against the fixed bounds
  assign outside = (rate > rate_max) || (rate < rate_min);
  assign diff    = (RW+1)'(rate) - (RW+1)'(bias);
  assign prod    = (2*RW+2)'(diff) * (2*RW+2)'($signed({1'b0, req.dt_us}));

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_max     <= gbdi_pkg::RATE_MAX_RESET;
      rate_min     <= gbdi_pkg::RATE_MIN_RESET;
      rate_sum     <= '0;
      sample_count <= '0;
      bias         <= '0;
      cal_done     <= 1'b0;
    end else if (en) begin
      rate_max     <= rate_max_next;
      rate_min     <= rate_min_next;
      rate_sum     <= rate_sum_next;
      sample_count <= sample_count_next;
      bias         <= bias_next;
      cal_done     <= cal_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gyro.acc_en     <= (req.req_type == gbdi_pkg::REQ_RUN) && cal_done && outside;
      gyro.delta      <= gbdi_pkg::DELTA_W'(prod);
      gyro.calibrated <= cal_done_next;
    end
  end

endmodule

// ===== rtl/gbdi_merge.sv =====
// merge stage: sums the three squared axes against the threshold and
// folds the gyro product into the saturating angle; uses gbdi_pkg
`timescale 1ns / 1ps

module gbdi_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          is_accel,
  input  gbdi_pkg::gbdi_gyro_t          gyro,
  input  logic [2:0][gbdi_pkg::SQ_W-1:0] sq,
  input  logic [gbdi_pkg::THR_W-1:0]    thr,
  output gbdi_pkg::gbdi_rsp_t           rsp
);

  localparam int AW = gbdi_pkg::ANGLE_W;

  logic signed [AW-1:0] angle_acc, angle_acc_next;
  logic signed [AW:0]   sum_wide;
  logic [gbdi_pkg::THR_W-1:0] mag;

  // each square is at most 2**30, so three fit in the threshold width
  assign mag = gbdi_pkg::THR_W'(sq[0]) + gbdi_pkg::THR_W'(sq[1]) + gbdi_pkg::THR_W'(sq[2]);

  assign sum_wide = (AW+1)'(angle_acc) + (AW+1)'(gyro.delta);

  always_comb begin
    angle_acc_next = angle_acc;
    if (gyro.acc_en) begin
      if (sum_wide[AW] != sum_wide[AW-1]) begin
        // saturate toward the sign of the true sum
        angle_acc_next = sum_wide[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end else begin
        angle_acc_next = AW'(sum_wide);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_acc <= '0;
    end else if (load) begin
      angle_acc <= angle_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.angle      <= angle_acc_next;
      rsp.collision  <= is_accel && (mag > thr);
      rsp.calibrated <= gyro.calibrated;
    end
  end

endmodule

// ===== rtl/gyro_bias_deadband_integrator_top.sv =====
// top level of the gyro bias / deadband integrator with collision check
// instantiates gbdi_gyro_core, three gbdi_sq_lane and gbdi_merge; uses gbdi_pkg
//
//   channel  signals                        direction  payload
//   in       in_valid / in_ready / in_data  request    gbdi_req_t
//   out      out_valid / out_ready / out_data  response gbdi_rsp_t
//   cfg      cfg_we / cfg_wdata             write      collision threshold squared
//
// one request per cycle while in_ready is high; two register stages (lane stage,
// then the merge and output register), and a response is presented from the
// output register once its request has passed the lane stage.
// the gyro lane's calibration registers and the angle accumulator each
// update as their request passes, so dependent requests can follow back to back.
// rst is synchronous; it clears calibration, angle and pipeline valids.
// a stalled response holds the output register; new requests still enter
// while the lane stage is empty.
`timescale 1ns / 1ps

module gyro_bias_deadband_integrator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gbdi_pkg::gbdi_req_t           in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gbdi_pkg::gbdi_rsp_t           out_data,
  input  logic                          cfg_we,
  input  logic [gbdi_pkg::THR_W-1:0]    cfg_wdata
);

  logic [gbdi_pkg::THR_W-1:0]     thr;
  logic                           s1_valid;
  logic                           s1_accel;
  logic                           adv_out, adv_s1, take;
  gbdi_pkg::gbdi_gyro_t           gyro;
  logic [2:0][gbdi_pkg::SQ_W-1:0] sq;

  assign adv_out  = !out_valid || out_ready;
  assign adv_s1   = !s1_valid || adv_out;
  assign in_ready = adv_s1;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= gbdi_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_valid <= take;
      end
      if (adv_out) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_accel <= (in_data.req_type == gbdi_pkg::REQ_ACCEL);
    end
  end

  gbdi_gyro_core u_gyro (
    .clk  (clk),
    .rst  (rst),
    .en   (take),
    .req  (in_data),
    .gyro (gyro)
  );

  gbdi_sq_lane u_sq_x (
    .clk  (clk),
    .en   (take),
    .axis (in_data.accel_x),
    .sq   (sq[0])
  );

  gbdi_sq_lane u_sq_y (
    .clk  (clk),
    .en   (take),
    .axis (in_data.accel_y),
    .sq   (sq[1])
  );

  gbdi_sq_lane u_sq_z (
    .clk  (clk),
    .en   (take),
    .axis (in_data.accel_z),
    .sq   (sq[2])
  );

  gbdi_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_valid && adv_out),
    .is_accel (s1_accel),
    .gyro     (gyro),
    .sq       (sq),
    .thr      (thr),
    .rsp      (out_data)
  );

endmodule

// ===== tb/tb.sv =====
// testbench for gyro_bias_deadband_integrator_top: calibration, deadband
// integration with long angle ramps, and the collision threshold
// depends on gbdi_pkg and the rtl under rtl/
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int LIMIT = 2_000_000;
  localparam logic signed [gbdi_pkg::ANGLE_W-1:0] ANGLE_CEIL  =
    {1'b0, {(gbdi_pkg::ANGLE_W-1){1'b1}}};
  localparam logic signed [gbdi_pkg::ANGLE_W-1:0] ANGLE_FLOOR =
    {1'b1, {(gbdi_pkg::ANGLE_W-1){1'b0}}};
  localparam logic [gbdi_pkg::THR_W-1:0] THR_TOP = 32'd3221225472;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  gbdi_pkg::gbdi_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gbdi_pkg::gbdi_rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [gbdi_pkg::THR_W-1:0] cfg_wdata = '0;

  bit idle_on = 1'b1;
  bit stall_on = 1'b1;
  int err_cnt = 0;
  int cycles = 0;
  gbdi_pkg::gbdi_rsp_t rsp_due[$];

  // own copy of the block state
  logic signed [gbdi_pkg::RATE_W-1:0]  hi_bound;
  logic signed [gbdi_pkg::RATE_W-1:0]  lo_bound;
  logic signed [gbdi_pkg::SUM_W-1:0]   rate_total;
  logic [gbdi_pkg::CNT_W-1:0]          calib_cnt;
  logic signed [gbdi_pkg::RATE_W-1:0]  gyro_bias;
  logic signed [gbdi_pkg::ANGLE_W-1:0] angle_pred;
  logic                                cal_ok;
  logic [gbdi_pkg::THR_W-1:0]          thr_pred;

  gyro_bias_deadband_integrator_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic void imu_reset();
    hi_bound   = gbdi_pkg::RATE_MAX_RESET;
    lo_bound   = gbdi_pkg::RATE_MIN_RESET;
    rate_total = '0;
    calib_cnt  = '0;
    gyro_bias  = '0;
    angle_pred = '0;
    cal_ok     = 1'b0;
    thr_pred   = gbdi_pkg::THR_RESET;
  endfunction

  // advance the state by one request and return the response it produces
  function automatic gbdi_pkg::gbdi_rsp_t step_imu(input gbdi_pkg::gbdi_req_t r);
    gbdi_pkg::gbdi_rsp_t rsp;
    int rate, hi;
    longint sum, ax, ay, az;
    rsp = '0;
    rate = int'($signed(r.gyro_rate));
    case (r.req_type)
      gbdi_pkg::REQ_CALIB: begin
        if (!cal_ok) begin
          if (rate > hi_bound) hi_bound = gbdi_pkg::RATE_W'(rate);
          if (rate < lo_bound) lo_bound = gbdi_pkg::RATE_W'(rate);
          rate_total = gbdi_pkg::SUM_W'(int'(rate_total) + rate);
          calib_cnt = calib_cnt + 1'b1;
          if (calib_cnt >= gbdi_pkg::CALIB_SAMPLES) begin
            gyro_bias = gbdi_pkg::RATE_W'(int'(rate_total) / gbdi_pkg::CALIB_SAMPLES);
            hi = int'(hi_bound) * 11 / 10;
            if (hi > int'(gbdi_pkg::RATE_POS_LIMIT)) hi = int'(gbdi_pkg::RATE_POS_LIMIT);
            hi_bound = gbdi_pkg::RATE_W'(hi);
            lo_bound = gbdi_pkg::RATE_W'(int'(lo_bound) / 10);
            cal_ok = 1'b1;
          end
        end
      end
      gbdi_pkg::REQ_RUN: begin
        if (cal_ok && (rate > hi_bound || rate < lo_bound)) begin
          sum = longint'(angle_pred) +
                longint'(rate - int'(gyro_bias)) * longint'(r.dt_us);
          if (sum > longint'(ANGLE_CEIL)) sum = longint'(ANGLE_CEIL);
          if (sum < longint'(ANGLE_FLOOR)) sum = longint'(ANGLE_FLOOR);
          angle_pred = gbdi_pkg::ANGLE_W'(sum);
        end
      end
      gbdi_pkg::REQ_ACCEL: begin
        ax = longint'($signed(r.accel_x));
        ay = longint'($signed(r.accel_y));
        az = longint'($signed(r.accel_z));
        rsp.collision = (ax * ax + ay * ay + az * az) > longint'(thr_pred);
      end
      default: begin
      end
    endcase
    rsp.angle = angle_pred;
    rsp.calibrated = cal_ok;
    return rsp;
  endfunction

  function automatic gbdi_pkg::gbdi_req_t pick_req();
    gbdi_pkg::gbdi_req_t r;
    r.req_type  = 2'($urandom_range(0, 3));
    r.gyro_rate = gbdi_pkg::RATE_W'($urandom);
    r.dt_us     = gbdi_pkg::DT_W'($urandom);
    r.accel_x   = gbdi_pkg::ACC_W'($urandom);
    r.accel_y   = gbdi_pkg::ACC_W'($urandom);
    r.accel_z   = gbdi_pkg::ACC_W'($urandom);
    return r;
  endfunction

  task automatic log_err(input string what, input longint want, input longint got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch: %s expected %0d got %0d", what, want, got);
  endtask

  always @(posedge clk) begin
    out_ready <= !(stall_on && $urandom_range(0, 99) < 33);
  end

  always @(posedge clk) begin : rsp_check
    gbdi_pkg::gbdi_rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (rsp_due.size() == 0) begin
        log_err("response with no request pending, angle", 0, out_data.angle);
      end else begin
        want = rsp_due.pop_front();
        if (out_data.angle !== want.angle)
          log_err("angle", want.angle, out_data.angle);
        if (out_data.collision !== want.collision)
          log_err("collision", want.collision, out_data.collision);
        if (out_data.calibrated !== want.calibrated)
          log_err("calibrated", want.calibrated, out_data.calibrated);
      end
    end
  end

  // hold the request until it is taken, then record its expected response
  task automatic send_req(input gbdi_pkg::gbdi_req_t r);
    while (idle_on && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rsp_due.push_back(step_imu(r));
  endtask

  task automatic send_gyro(input logic [1:0] kind, input int rate, input int dt);
    gbdi_pkg::gbdi_req_t r;
    r = pick_req();
    r.req_type  = kind;
    r.gyro_rate = gbdi_pkg::RATE_W'(rate);
    r.dt_us     = gbdi_pkg::DT_W'(dt);
    send_req(r);
  endtask

  task automatic send_accel(input int x, input int y, input int z);
    gbdi_pkg::gbdi_req_t r;
    r = pick_req();
    r.req_type = gbdi_pkg::REQ_ACCEL;
    r.accel_x  = gbdi_pkg::ACC_W'(x);
    r.accel_y  = gbdi_pkg::ACC_W'(y);
    r.accel_z  = gbdi_pkg::ACC_W'(z);
    send_req(r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [gbdi_pkg::THR_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    thr_pred = v;
  endtask

  // run requests are ignored until calibrated; default threshold is 11469 squared
  task automatic test_reset_state();
    send_gyro(gbdi_pkg::REQ_RUN, 32767, 65535);
    send_gyro(gbdi_pkg::REQ_RUN, -32768, 65535);
    send_gyro(REQ_UNUSED, 32767, 65535);
    send_accel(0, 0, 0);
    send_accel(11469, 0, 0);
    send_accel(11469, 1, 0);
    send_accel(-32768, -32768, -32768);
  endtask

  task automatic test_threshold_extremes();
    write_threshold('0);
    send_accel(0, 0, 0);
    send_accel(0, 0, -1);
    write_threshold(THR_TOP);
    send_accel(-32768, -32768, -32768);
    send_accel(32767, 32767, 32767);
    write_threshold(THR_TOP - 1);
    send_accel(-32768, -32768, -32768);
    write_threshold(gbdi_pkg::THR_RESET);
  endtask

  // saturating upper bound from the 32767 sample, lower bound from -32768,
  // and a strongly negative bias so both signs of delta stay reachable
  task automatic test_calibration();
    gbdi_pkg::gbdi_req_t r;
    int rate;
    for (int i = 0; i < gbdi_pkg::CALIB_SAMPLES; i++) begin
      while ($urandom_range(0, 5) == 0) begin
        r = pick_req();
        if (r.req_type == gbdi_pkg::REQ_CALIB) r.req_type = gbdi_pkg::REQ_ACCEL;
        send_req(r);
      end
      if (i == 0) rate = 32767;
      else if (i == 1) rate = -32768;
      else rate = -int'($urandom_range(8000, 28000));
      send_gyro(gbdi_pkg::REQ_CALIB, rate, int'($urandom_range(0, 65535)));
    end
  endtask

  task automatic test_deadband_edges();
    send_gyro(gbdi_pkg::REQ_RUN, hi_bound, 65535);
    send_gyro(gbdi_pkg::REQ_RUN, lo_bound, 65535);
    send_gyro(gbdi_pkg::REQ_RUN, 0, 65535);
    send_gyro(gbdi_pkg::REQ_RUN, int'(lo_bound) - 1, 0);
    send_gyro(gbdi_pkg::REQ_RUN, int'(lo_bound) - 1, 65535);
    send_gyro(gbdi_pkg::REQ_RUN, -32768, 65535);
    send_gyro(gbdi_pkg::REQ_RUN, gyro_bias, 65535);
    send_gyro(gbdi_pkg::REQ_RUN, -32768, 1);
    // late calibration requests must not move the bounds
    send_gyro(gbdi_pkg::REQ_CALIB, 32767, 0);
    send_gyro(gbdi_pkg::REQ_CALIB, -32768, 0);
    send_gyro(gbdi_pkg::REQ_RUN, int'(lo_bound) - 1, 1000);
    send_gyro(REQ_UNUSED, -1, 65535);
  endtask

  function automatic gbdi_pkg::gbdi_req_t traffic_req();
    gbdi_pkg::gbdi_req_t r;
    int pick;
    r = pick_req();
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.req_type = gbdi_pkg::REQ_RUN;
      if ($urandom_range(0, 4) == 0)
        r.gyro_rate = gbdi_pkg::RATE_W'(int'(lo_bound) + int'($urandom_range(0, 4)) - 2);
    end else if (pick < 85) begin
      r.req_type = gbdi_pkg::REQ_ACCEL;
      if ($urandom_range(0, 1) == 0) begin
        r.accel_x = gbdi_pkg::ACC_W'(int'($urandom_range(0, 24000)) - 12000);
        r.accel_y = gbdi_pkg::ACC_W'(int'($urandom_range(0, 24000)) - 12000);
        r.accel_z = gbdi_pkg::ACC_W'(int'($urandom_range(0, 24000)) - 12000);
      end
    end else if (pick < 93) begin
      r.req_type = gbdi_pkg::REQ_CALIB;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic test_random_traffic(input int phases, input int per_phase);
    logic [gbdi_pkg::THR_W-1:0] thr;
    for (int p = 0; p < phases; p++) begin
      case (p % 5)
        1: thr = '0;
        3: thr = THR_TOP;
        default: thr = gbdi_pkg::THR_W'($urandom_range(0, THR_TOP));
      endcase
      write_threshold(thr);
      // one phase runs with both sides always ready
      idle_on = (p != 2);
      stall_on <= (p != 2);
      for (int i = 0; i < per_phase; i++) send_req(traffic_req());
    end
    idle_on = 1'b1;
    stall_on <= 1'b1;
  endtask

  // long one-sided runs of large deltas, first upward, then downward
  task automatic test_angle_ramp(input int steps);
    settle();
    idle_on = 1'b0;
    stall_on <= 1'b0;
    for (int i = 0; i < steps; i++)
      send_gyro(gbdi_pkg::REQ_RUN, int'(lo_bound) - 1, int'($urandom_range(60000, 65535)));
    for (int i = 0; i < steps; i++)
      send_gyro(gbdi_pkg::REQ_RUN, -32768, int'($urandom_range(60000, 65535)));
    idle_on = 1'b1;
    stall_on <= 1'b1;
  endtask

  initial begin
    imu_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_threshold_extremes();
    test_calibration();
    test_deadband_edges();
    test_random_traffic(5, 200);
    test_angle_ramp(40);
    test_random_traffic(1, 50);
    settle();
    if (err_cnt == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== gyro_bias_deadband_integrator_top.f =====
rtl/gbdi_pkg.sv
rtl/gbdi_sq_lane.sv
rtl/gbdi_gyro_core.sv
rtl/gbdi_merge.sv
rtl/gyro_bias_deadband_integrator_top.sv
tb/tb.sv
